>>> design/c128b_pkg.sv
// ----------------------------------------------------------------------------
// c128b_pkg
// shared types, constants and symbol tables for the code 128 set b encoder
// ----------------------------------------------------------------------------
`default_nettype none

package c128b_pkg;

   localparam int CODE_W    = 16;
   localparam int VALUE_W   = 7;
   localparam int PATTERN_W = 11;
   localparam int BITS_W    = 13;
   localparam int COUNT_W   = 4;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int SUM_W     = VALUE_W + 2;
   localparam int NUM_DATA_SYMBOLS = 106;
   localparam int TABLE_DEPTH      = 2 ** VALUE_W;

   localparam logic [CODE_W-1:0]  FIRST_PRINTABLE = 16'd32;
   localparam logic [CODE_W-1:0]  LAST_PRINTABLE  = 16'd126;
   localparam logic [VALUE_W-1:0] SUBSTITUTE_VALUE = 7'd13;
   localparam logic [VALUE_W-1:0] START_B_VALUE    = 7'd104;
   localparam logic [VALUE_W-1:0] STOP_VALUE       = 7'd106;
   localparam logic [VALUE_W-1:0] CHECK_MODULUS    = 7'd103;
   localparam logic [VALUE_W-1:0] LAST_WEIGHT      = 7'd102;
   localparam logic [VALUE_W-1:0] INITIAL_WEIGHT   = 7'd1;
   localparam logic [VALUE_W-1:0] INITIAL_REMAINDER = 7'd1;
   localparam logic [COUNT_W-1:0] SYMBOL_MODULES   = 4'd11;
   localparam logic [COUNT_W-1:0] STOP_MODULES     = 4'd13;
   localparam logic [BITS_W-1:0]  STOP_PATTERN     = 13'b1100011101011;

   typedef logic [23:0] width_code_type;
   typedef logic [PATTERN_W-1:0] pattern_table_type [TABLE_DEPTH];
   typedef logic [VALUE_W-1:0] fold_table_type [TABLE_DEPTH];

   // element widths, bar first, one nibble per element
   localparam width_code_type WIDTH_CODES [NUM_DATA_SYMBOLS] = '{
      24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322,
      24'h131222, 24'h122213, 24'h122312, 24'h132212, 24'h221213,
      24'h221312, 24'h231212, 24'h112232, 24'h122132, 24'h122231,
      24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132,
      24'h221231, 24'h213212, 24'h223112, 24'h312131, 24'h311222,
      24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
      24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
      24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313,
      24'h231113, 24'h231311, 24'h112133, 24'h112331, 24'h132131,
      24'h113123, 24'h113321, 24'h133121, 24'h313121, 24'h211331,
      24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123,
      24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
      24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422,
      24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
      24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211,
      24'h241211, 24'h221114, 24'h413111, 24'h241112, 24'h134111,
      24'h111242, 24'h121142, 24'h121241, 24'h114212, 24'h124112,
      24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
      24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141,
      24'h114113, 24'h114311, 24'h411113, 24'h411311, 24'h113141,
      24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
      24'h211232
   };

   function automatic pattern_table_type build_patterns();
      pattern_table_type t;
      logic [PATTERN_W-1:0] bits;
      logic bar;
      int n;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         t[i] = '0;
      end
      for (int i = 0; i < NUM_DATA_SYMBOLS; i++) begin
         bits = '0;
         bar  = 1'b1;
         for (int d = 0; d < 6; d++) begin
            n = int'(WIDTH_CODES[i][23 - 4 * d -: 4]);
            for (int k = 0; k < n; k++) begin
               bits = {bits[PATTERN_W-2:0], bar};
            end
            bar = ~bar;
         end
         t[i] = bits;
      end
      return t;
   endfunction

   // (h * 128) mod 103 for the upper half of a product
   function automatic fold_table_type build_fold();
      fold_table_type t;
      for (int h = 0; h < TABLE_DEPTH; h++) begin
         t[h] = VALUE_W'((h * TABLE_DEPTH) % 103);
      end
      return t;
   endfunction

   localparam pattern_table_type PATTERN_TABLE = build_patterns();
   localparam fold_table_type    FOLD_TABLE    = build_fold();

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic               last;
   } hold_type;

   typedef struct packed {
      logic               data_emit;
      logic               clear;
      logic [VALUE_W-1:0] value;
   } csum_ctl_type;

   typedef struct packed {
      logic [VALUE_W-1:0] remainder;
      logic               busy;
   } csum_sts_type;

endpackage

`default_nettype wire

>>> design/c128b_input_stage.sv
// ----------------------------------------------------------------------------
// c128b_input_stage
// maps the character to its set b value and holds it until its symbols are out
// ----------------------------------------------------------------------------
`default_nettype none

module c128b_input_stage
   import c128b_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CODE_W-1:0] req_char_code,
   input  wire logic              req_last_char,
   input  wire logic              item_done,
   output hold_type               hold
);

   logic               valid_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               last_ff;
   logic [VALUE_W-1:0] value_in;
   logic [CODE_W-1:0]  offset;

   assign offset = req_char_code - FIRST_PRINTABLE;

   always_comb begin
      if ((req_char_code < FIRST_PRINTABLE) || (req_char_code > LAST_PRINTABLE)) begin
         value_in = SUBSTITUTE_VALUE;
      end else begin
         value_in = offset[VALUE_W-1:0];
      end
   end

   assign req_ready = !valid_ff || item_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         valid_ff <= 1'b1;
      end else if (item_done) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         value_ff <= value_in;
         last_ff  <= req_last_char;
      end
   end

   assign hold.valid = valid_ff;
   assign hold.value = value_ff;
   assign hold.last  = last_ff;

endmodule

`default_nettype wire

>>> design/c128b_checksum.sv
// ----------------------------------------------------------------------------
// c128b_checksum
// weighted mod 103 checksum: registered product, then fold and accumulate
// ----------------------------------------------------------------------------
`default_nettype none

module c128b_checksum
   import c128b_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire csum_ctl_type ctl,
   output csum_sts_type sts
);

   logic [VALUE_W-1:0] weight_ff;
   logic [VALUE_W-1:0] weight_in;
   logic [PROD_W-1:0]  prod_ff;
   logic               prod_valid_ff;
   logic [VALUE_W-1:0] rem_ff;
   logic [VALUE_W-1:0] rem_in;
   logic [SUM_W-1:0]   sum;

   always_comb begin
      if (weight_ff == LAST_WEIGHT) begin
         weight_in = '0;
      end else begin
         weight_in = weight_ff + 7'd1;
      end
   end

   // high half of the product folded through a table, then one subtract of up to three times 103
   assign sum = SUM_W'(FOLD_TABLE[prod_ff[PROD_W-1:VALUE_W]]) + SUM_W'(prod_ff[VALUE_W-1:0])
              + SUM_W'(rem_ff);

   always_comb begin
      if (sum >= SUM_W'(3 * 103)) begin
         rem_in = VALUE_W'(sum - SUM_W'(3 * 103));
      end else if (sum >= SUM_W'(2 * 103)) begin
         rem_in = VALUE_W'(sum - SUM_W'(2 * 103));
      end else if (sum >= SUM_W'(CHECK_MODULUS)) begin
         rem_in = VALUE_W'(sum - SUM_W'(CHECK_MODULUS));
      end else begin
         rem_in = sum[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff     <= INITIAL_WEIGHT;
         rem_ff        <= INITIAL_REMAINDER;
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.data_emit;
         if (ctl.clear) begin
            weight_ff <= INITIAL_WEIGHT;
         end else if (ctl.data_emit) begin
            weight_ff <= weight_in;
         end
         if (ctl.clear) begin
            rem_ff <= INITIAL_REMAINDER;
         end else if (prod_valid_ff) begin
            rem_ff <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.data_emit) begin
         prod_ff <= weight_ff * ctl.value;
      end
   end

   assign sts.remainder = rem_ff;
   assign sts.busy      = prod_valid_ff;

endmodule

`default_nettype wire

>>> design/c128b_sequencer.sv
// ----------------------------------------------------------------------------
// c128b_sequencer
// orders start, data, checksum and stop symbols into the result register
// ----------------------------------------------------------------------------
`default_nettype none

module c128b_sequencer
   import c128b_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hold_type            hold,
   output logic                     item_done,
   output csum_ctl_type             csum_ctl,
   input  wire csum_sts_type        csum_sts,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [VALUE_W-1:0]       rsp_symbol_value,
   output logic [BITS_W-1:0]        rsp_module_bits,
   output logic [COUNT_W-1:0]       rsp_module_count,
   output logic                     rsp_last_symbol
);

   typedef enum logic [1:0] {
      PH_MAIN,
      PH_CHECK,
      PH_STOP
   } phase_type;

   phase_type          phase_ff;
   phase_type          phase_in;
   logic               open_ff;
   logic               open_in;
   logic               out_free;
   logic               emit;
   logic               is_stop;
   logic [VALUE_W-1:0] sel_value;

   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [BITS_W-1:0]  bits_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      phase_in           = phase_ff;
      open_in            = open_ff;
      emit               = 1'b0;
      is_stop            = 1'b0;
      item_done          = 1'b0;
      sel_value          = hold.value;
      csum_ctl.data_emit = 1'b0;
      csum_ctl.clear     = 1'b0;
      csum_ctl.value     = hold.value;
      if (hold.valid && out_free) begin
         case (phase_ff)
            PH_MAIN: begin
               emit = 1'b1;
               if (!open_ff) begin
                  sel_value = START_B_VALUE;
                  open_in   = 1'b1;
               end else begin
                  csum_ctl.data_emit = 1'b1;
                  if (hold.last) begin
                     phase_in = PH_CHECK;
                  end else begin
                     item_done = 1'b1;
                  end
               end
            end
            PH_CHECK: begin
               // wait until the last product has been accumulated
               if (!csum_sts.busy) begin
                  emit      = 1'b1;
                  sel_value = csum_sts.remainder;
                  phase_in  = PH_STOP;
               end
            end
            PH_STOP: begin
               emit           = 1'b1;
               is_stop        = 1'b1;
               sel_value      = STOP_VALUE;
               open_in        = 1'b0;
               phase_in       = PH_MAIN;
               item_done      = 1'b1;
               csum_ctl.clear = 1'b1;
            end
            default: begin
               phase_in = PH_MAIN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAIN;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         open_ff  <= open_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         value_ff <= sel_value;
         last_ff  <= is_stop;
         if (is_stop) begin
            bits_ff  <= STOP_PATTERN;
            count_ff <= STOP_MODULES;
         end else begin
            bits_ff  <= BITS_W'(PATTERN_TABLE[sel_value]);
            count_ff <= SYMBOL_MODULES;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol_value = value_ff;
   assign rsp_module_bits  = bits_ff;
   assign rsp_module_count = count_ff;
   assign rsp_last_symbol  = last_ff;

endmodule

`default_nettype wire

>>> design/code128_set_b_symbol_encoder.sv
// ----------------------------------------------------------------------------
// code128_set_b_symbol_encoder
// code 128 set b encoder: one character in, its bar/space symbols out
// ----------------------------------------------------------------------------
// Each character transaction yields its results in order while rsp_ready is
// high: a mid-message character gives its data symbol, the first character of a
// message start B and then data, and the last character data, a wait for the
// checksum accumulator to settle, checksum and stop, with start B first in a
// one-character message. The pace is set by the single result register and by
// the two-step checksum path (registered weight * value product, then table
// fold and mod 103 accumulate). Codes outside 32..126 encode as '-'. Module
// patterns are right aligned, first module at bit module_count-1, 1 = bar.
// ----------------------------------------------------------------------------
`default_nettype none

module code128_set_b_symbol_encoder
   import c128b_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [CODE_W-1:0]   req_char_code,
   input  wire logic                req_last_char,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [VALUE_W-1:0]       rsp_symbol_value,
   output logic [BITS_W-1:0]        rsp_module_bits,
   output logic [COUNT_W-1:0]       rsp_module_count,
   output logic                     rsp_last_symbol
);

   hold_type     hold;
   logic         item_done;
   csum_ctl_type csum_ctl;
   csum_sts_type csum_sts;

   c128b_input_stage u_input_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .item_done     (item_done),
      .hold          (hold)
   );

   c128b_checksum u_checksum (
      .clock (clock),
      .reset (reset),
      .ctl   (csum_ctl),
      .sts   (csum_sts)
   );

   c128b_sequencer u_sequencer (
      .clock            (clock),
      .reset            (reset),
      .hold             (hold),
      .item_done        (item_done),
      .csum_ctl         (csum_ctl),
      .csum_sts         (csum_sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol_value (rsp_symbol_value),
      .rsp_module_bits  (rsp_module_bits),
      .rsp_module_count (rsp_module_count),
      .rsp_last_symbol  (rsp_last_symbol)
   );

endmodule

`default_nettype wire

>>> design/c128b_checker.sv
// ----------------------------------------------------------------------------
// c128b_checker
// port-level checks on the result channel of the encoder
// ----------------------------------------------------------------------------
`default_nettype none

module c128b_checker
   import c128b_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [VALUE_W-1:0]  rsp_symbol_value,
   input wire logic [BITS_W-1:0]   rsp_module_bits,
   input wire logic [COUNT_W-1:0]  rsp_module_count,
   input wire logic                rsp_last_symbol
);

   // stalled transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol_value)
         && $stable(rsp_module_bits) && $stable(rsp_last_symbol))
      else $error("stalled result changed");

   // stop symbol carries its own length and value, everything else is 11 modules
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_symbol && rsp_module_count == STOP_MODULES
                        && rsp_symbol_value == STOP_VALUE)
                 || (!rsp_last_symbol && rsp_module_count == SYMBOL_MODULES
                        && rsp_symbol_value != STOP_VALUE))
      else $error("symbol length mismatch");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_symbol |-> rsp_module_bits == STOP_PATTERN)
      else $error("bad stop pattern");

   // ordinary symbols start with a bar and end with a space
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_symbol |-> rsp_module_bits[12:10] == 3'b001
         && !rsp_module_bits[0])
      else $error("bad symbol pattern");

endmodule

bind code128_set_b_symbol_encoder c128b_checker u_c128b_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_symbol_value (rsp_symbol_value),
   .rsp_module_bits  (rsp_module_bits),
   .rsp_module_count (rsp_module_count),
   .rsp_last_symbol  (rsp_last_symbol)
);

`default_nettype wire

>>> tb/code128_symbol_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// code128_symbol_checker
// Watches the character and symbol channels of the code 128 set b encoder.
// Every accepted character is turned into the symbols it should produce.
// These are start b for the first character of a message, the data symbol,
// then checksum and stop at the end of a message. Each accepted symbol is
// compared field by field with the oldest symbol still waiting.
// ----------------------------------------------------------------------------

module code128_symbol_checker
   import c128b_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [CODE_W-1:0]  req_char_code,
   input  logic               req_last_char,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [VALUE_W-1:0] rsp_symbol_value,
   input  logic [BITS_W-1:0]  rsp_module_bits,
   input  logic [COUNT_W-1:0] rsp_module_count,
   input  logic               rsp_last_symbol,
   output int                 error_count,
   output int                 pending_symbols
);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [BITS_W-1:0]  bits;
      logic [COUNT_W-1:0] count;
      logic               last;
   } symbol_type;

   // bar and space widths, bar first, one nibble each, 0 ends the symbol
   localparam logic [27:0] ELEMENT_WIDTHS [107] = '{
      28'h2122220, 28'h2221220, 28'h2222210, 28'h1212230, 28'h1213220,
      28'h1312220, 28'h1222130, 28'h1223120, 28'h1322120, 28'h2212130,
      28'h2213120, 28'h2312120, 28'h1122320, 28'h1221320, 28'h1222310,
      28'h1132220, 28'h1231220, 28'h1232210, 28'h2232110, 28'h2211320,
      28'h2212310, 28'h2132120, 28'h2231120, 28'h3121310, 28'h3112220,
      28'h3211220, 28'h3212210, 28'h3122120, 28'h3221120, 28'h3222110,
      28'h2121230, 28'h2123210, 28'h2321210, 28'h1113230, 28'h1311230,
      28'h1313210, 28'h1123130, 28'h1321130, 28'h1323110, 28'h2113130,
      28'h2311130, 28'h2313110, 28'h1121330, 28'h1123310, 28'h1321310,
      28'h1131230, 28'h1133210, 28'h1331210, 28'h3131210, 28'h2113310,
      28'h2311310, 28'h2131130, 28'h2133110, 28'h2131310, 28'h3111230,
      28'h3113210, 28'h3311210, 28'h3121130, 28'h3123110, 28'h3321110,
      28'h3141110, 28'h2214110, 28'h4311110, 28'h1112240, 28'h1114220,
      28'h1211240, 28'h1214210, 28'h1411220, 28'h1412210, 28'h1122140,
      28'h1124120, 28'h1221140, 28'h1224110, 28'h1421120, 28'h1422110,
      28'h2412110, 28'h2211140, 28'h4131110, 28'h2411120, 28'h1341110,
      28'h1112420, 28'h1211420, 28'h1212410, 28'h1142120, 28'h1241120,
      28'h1242110, 28'h4112120, 28'h4211120, 28'h4212110, 28'h2121410,
      28'h2141210, 28'h4121210, 28'h1111430, 28'h1113410, 28'h1311410,
      28'h1141130, 28'h1143110, 28'h4111130, 28'h4113110, 28'h1131410,
      28'h1141310, 28'h3111410, 28'h4111310, 28'h2114120, 28'h2112140,
      28'h2112320, 28'h2331112
   };

   symbol_type  expected_symbols [$];
   logic        message_open;
   int unsigned char_weight;
   int unsigned running_checksum;

   function automatic symbol_type encode_symbol(input logic [VALUE_W-1:0] value,
                                                input logic last);
      symbol_type s;
      int         n;
      logic       bar;
      s.value = value;
      s.bits  = '0;
      s.count = '0;
      s.last  = last;
      bar     = 1'b1;
      for (int d = 0; d < 7; d++) begin
         n = int'(ELEMENT_WIDTHS[value][27 - 4 * d -: 4]);
         for (int k = 0; k < n; k++) begin
            s.bits  = {s.bits[BITS_W-2:0], bar};
            s.count = s.count + 1'b1;
         end
         bar = ~bar;
      end
      return s;
   endfunction

   task automatic predict_char_symbols(input logic [CODE_W-1:0] code, input logic last);
      logic [VALUE_W-1:0] value;
      if (!message_open) begin
         message_open     = 1'b1;
         char_weight      = INITIAL_WEIGHT;
         running_checksum = INITIAL_REMAINDER;
         expected_symbols.push_back(encode_symbol(START_B_VALUE, 1'b0));
      end
      if (code < FIRST_PRINTABLE || code > LAST_PRINTABLE) begin
         value = SUBSTITUTE_VALUE;
      end else begin
         value = VALUE_W'(code - FIRST_PRINTABLE);
      end
      expected_symbols.push_back(encode_symbol(value, 1'b0));
      running_checksum = (running_checksum + char_weight * value) % CHECK_MODULUS;
      char_weight = char_weight + 1;
      if (char_weight >= CHECK_MODULUS) begin
         char_weight = 0;
      end
      if (last) begin
         expected_symbols.push_back(encode_symbol(VALUE_W'(running_checksum), 1'b0));
         expected_symbols.push_back(encode_symbol(STOP_VALUE, 1'b1));
         message_open     = 1'b0;
         char_weight      = INITIAL_WEIGHT;
         running_checksum = INITIAL_REMAINDER;
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count = error_count + 1;
      end
   endtask

   always @(posedge clock) begin
      symbol_type want;
      if (reset) begin
         expected_symbols.delete();
         message_open     = 1'b0;
         char_weight      = INITIAL_WEIGHT;
         running_checksum = INITIAL_REMAINDER;
         error_count      = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_char_symbols(req_char_code, req_last_char);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_symbols.size() == 0) begin
               $display("%0t: unexpected symbol, expected none, actual value %0d",
                        $time, rsp_symbol_value);
               error_count = error_count + 1;
            end else begin
               want = expected_symbols.pop_front();
               compare_field("symbol_value", want.value, rsp_symbol_value);
               compare_field("module_bits", want.bits, rsp_module_bits);
               compare_field("module_count", want.count, rsp_module_count);
               compare_field("last_symbol", want.last, rsp_last_symbol);
            end
         end
      end
      pending_symbols = expected_symbols.size();
   end

endmodule

>>> tb/code128_set_b_symbol_encoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// code128_set_b_symbol_encoder_test
// Drives character transactions into the code 128 set b encoder. A directed
// set of edge codes and short messages comes first, then random messages of
// mixed length with one long message that wraps the weight. The sender works
// in bursts with gaps and the receiver stalls on its own pattern, including
// one long hold-off. The checker module does all prediction and comparison.
// ----------------------------------------------------------------------------

module code128_set_b_symbol_encoder_test;
   import c128b_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_CHARS = 460;
   localparam int LONG_MESSAGE = 130;
   localparam int HOLD_CYCLES  = 400;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_BURSTS
   } stall_mode_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [CODE_W-1:0]  req_char_code = '0;
   logic               req_last_char = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [VALUE_W-1:0] rsp_symbol_value;
   logic [BITS_W-1:0]  rsp_module_bits;
   logic [COUNT_W-1:0] rsp_module_count;
   logic               rsp_last_symbol;

   logic               hold_request  = 1'b0;
   logic               hold_taken;
   int                 hold_left;
   int                 cycle_count   = 0;
   int                 burst_left    = 0;
   int                 error_count;
   int                 pending_symbols;
   stall_mode_type     stall_mode;

   code128_set_b_symbol_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol_value (rsp_symbol_value),
      .rsp_module_bits  (rsp_module_bits),
      .rsp_module_count (rsp_module_count),
      .rsp_last_symbol  (rsp_last_symbol)
   );

   code128_symbol_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol_value (rsp_symbol_value),
      .rsp_module_bits  (rsp_module_bits),
      .rsp_module_count (rsp_module_count),
      .rsp_last_symbol  (rsp_last_symbol),
      .error_count      (error_count),
      .pending_symbols  (pending_symbols)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver
   always @(posedge clock) begin
      stall_mode = stall_mode_type'(cycle_count[7:6]);
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         rsp_ready  <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         case (stall_mode)
            READY_ALWAYS: begin
               rsp_ready <= 1'b1;
            end
            READY_HALF: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            READY_SPARSE: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ready <= (cycle_count[2] == 1'b0);
            end
         endcase
      end
   end

   task automatic send_char(input logic [CODE_W-1:0] code, input logic last);
      int gap;
      req_valid     <= 1'b1;
      req_char_code <= code;
      req_last_char <= last;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left = burst_left - 1;
      end else begin
         if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(30, 60);
         end else begin
            burst_left = $urandom_range(0, 15);
         end
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_symbols();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_symbols != 0);
      @(posedge clock);
   endtask

   function automatic logic [CODE_W-1:0] random_code();
      logic [CODE_W-1:0] code;
      case ($urandom_range(0, 9))
         0: code = CODE_W'($urandom_range(0, 65535));
         1: code = CODE_W'($urandom_range(0, 31));
         default: code = CODE_W'($urandom_range(32, 126));
      endcase
      return code;
   endfunction

   initial begin
      int   sent;
      int   msg_len;
      logic long_done;
      sent      = 0;
      long_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // edge codes and short messages
      send_char(16'd65, 1'b1);
      send_char(16'd32, 1'b0);
      send_char(16'd126, 1'b0);
      send_char(16'd31, 1'b0);
      send_char(16'd127, 1'b0);
      send_char(16'h0000, 1'b0);
      send_char(16'hFFFF, 1'b0);
      send_char(16'h5555, 1'b0);
      send_char(16'hAAAA, 1'b0);
      send_char(16'd45, 1'b0);
      send_char(16'd33, 1'b1);
      send_char(16'h0000, 1'b1);
      send_char(16'd126, 1'b0);
      send_char(16'd126, 1'b1);
      send_char(16'hFFFF, 1'b1);
      drain_symbols();

      while (sent < RANDOM_CHARS) begin
         if (!long_done && sent >= 200) begin
            msg_len   = LONG_MESSAGE;
            long_done = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            msg_len = $urandom_range(9, 30);
         end else begin
            msg_len = $urandom_range(1, 8);
         end
         for (int k = 0; k < msg_len; k++) begin
            if (sent == 100) begin
               hold_request <= 1'b1;
               burst_left = 60;
            end
            send_char(random_code(), k == msg_len - 1);
            sent = sent + 1;
            if (sent == 330) begin
               drain_symbols();
            end
         end
      end

      drain_symbols();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_symbols == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
